>>> src/gpf_pkg.sv
// Shared types for the Goldbach split finder: result codes and the
// controller/datapath command and status structs. No dependencies.
package gpf_pkg;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_ODD   = 2'd1,
      ST_TWO   = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   // What the result register takes as its two primes
   typedef enum logic [1:0] {
      OUT_ZERO = 2'd0,
      OUT_TWO  = 2'd1,
      OUT_PAIR = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        load_n;       // capture request word
      logic        pair_init;    // i = 3
      logic        pair_next;    // i += 2
      logic        test_first;   // v = i, restart divisor
      logic        test_second;  // v = n - i, restart divisor
      logic        div_start;    // load remainder unit with v
      logic        div_step;     // one restoring step
      logic        k_next;       // k += 2, square updated
      logic        out_load;     // write result register
      status_type  out_status;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic n_odd;
      logic n_is_two;
      logic n_is_four;
      logic pair_end;   // no candidate left
      logic sq_gt_v;    // k*k > v, v is prime
      logic div_last;
      logic rem_zero;
   } sts_type;

endpackage

>>> src/goldbach_partition_finder.sv
// Top level of the Goldbach split finder: joins gpf_ctrl and gpf_dp.
// Depends on gpf_pkg.
//
// Usage:
//   req channel: req_valid / req_stall with req_even_number. One word is taken
//   when the block is idle; req_stall stays high until its result is written
//   into the output register.
//   rsp channel: rsp_valid / rsp_stall with rsp_status, rsp_first_prime and
//   rsp_second_prime. The output register holds the word while rsp_stall is
//   high; the next request is taken meanwhile and its result waits inside.
// Sequence:
//   odd input, two and four: classified in S_CLASS, result loaded in S_DONE.
//   otherwise each trial divisor passes S_KCHK, S_DIV (bit-serial
//   remainder, one bit per cycle) and S_REM (compare); each surviving
//   candidate passes S_KCHK once more, each pair tried passes S_PAIR.
//   The remainder unit takes most of the time for a word.
// Throughput: one word in flight; the next is taken the cycle after a result
//   is loaded into the output register.
// Reset: synchronous; clears the controller and drops rsp_valid, any word
//   in flight is lost.
module goldbach_partition_finder #(
   parameter int NUM_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [NUM_WIDTH-1:0] req_even_number,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [NUM_WIDTH-1:0] rsp_first_prime,
   output logic [NUM_WIDTH-1:0] rsp_second_prime
);

   gpf_pkg::cmd_type cmd;
   gpf_pkg::sts_type sts;

   gpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gpf_dp #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .req_even_number  (req_even_number),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_first_prime  (rsp_first_prime),
      .rsp_second_prime (rsp_second_prime)
   );

endmodule

>>> src/gpf_dp.sv
// Datapath of the Goldbach split finder: candidate, divisor and square
// registers, a bit-serial remainder unit and the result register. Uses gpf_pkg.
module gpf_dp #(
   parameter int NUM_WIDTH = 16
) (
   input  logic                   clock,
   input  gpf_pkg::cmd_type       cmd,
   input  logic [NUM_WIDTH-1:0]   req_even_number,
   output gpf_pkg::sts_type       sts,
   output logic [1:0]             rsp_status,
   output logic [NUM_WIDTH-1:0]   rsp_first_prime,
   output logic [NUM_WIDTH-1:0]   rsp_second_prime
);

   localparam int W  = NUM_WIDTH;
   localparam int SW = NUM_WIDTH + 2;
   localparam int CW = $clog2(NUM_WIDTH);

   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  i_ff, i_in;
   logic [W-1:0]  v_ff, v_in;
   logic [W-1:0]  k_ff, k_in;
   logic [SW-1:0] sq_ff, sq_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    status_ff, status_in;
   logic [W-1:0]  first_ff, first_in;
   logic [W-1:0]  second_ff, second_in;

   logic [W-1:0]  j_w;
   logic [W:0]    trial_w;
   logic          ge_w;

   assign j_w     = n_ff - i_ff;
   assign trial_w = {rem_ff, quo_ff[W-1]};
   assign ge_w    = trial_w >= {1'b0, k_ff};

   assign sts.n_odd     = n_ff[0];
   assign sts.n_is_two  = n_ff == W'(2);
   assign sts.n_is_four = n_ff == W'(4);
   assign sts.pair_end  = (i_ff >= n_ff) || (j_w < W'(3));
   assign sts.sq_gt_v   = sq_ff > {2'b00, v_ff};
   assign sts.div_last  = cnt_ff == '0;
   assign sts.rem_zero  = rem_ff == '0;

   always_comb begin
      n_in      = n_ff;
      i_in      = i_ff;
      v_in      = v_ff;
      k_in      = k_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      first_in  = first_ff;
      second_in = second_ff;

      if (cmd.load_n) begin
         n_in = req_even_number;
      end
      if (cmd.pair_init) begin
         i_in = W'(3);
      end
      if (cmd.pair_next) begin
         i_in = i_ff + W'(2);
      end
      // Even divisors never divide an odd candidate, so k runs 3, 5, 7, ...
      if (cmd.test_first || cmd.test_second) begin
         v_in  = cmd.test_first ? i_ff : j_w;
         k_in  = W'(3);
         sq_in = SW'(9);
      end
      if (cmd.k_next) begin
         k_in  = k_ff + W'(2);
         sq_in = sq_ff + {k_ff, 2'b00} + SW'(4);   // (k+2)^2 = k^2 + 4k + 4
      end
      if (cmd.div_start) begin
         rem_in = '0;
         quo_in = v_ff;
         cnt_in = CW'(W - 1);
      end
      if (cmd.div_step) begin
         rem_in = ge_w ? W'(trial_w - {1'b0, k_ff}) : trial_w[W-1:0];
         quo_in = {quo_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.out_load) begin
         status_in = cmd.out_status;
         case (cmd.out_sel)
            gpf_pkg::OUT_TWO: begin
               first_in  = W'(2);
               second_in = W'(2);
            end
            gpf_pkg::OUT_PAIR: begin
               first_in  = i_ff;
               second_in = j_w;
            end
            default: begin
               first_in  = '0;
               second_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      i_ff      <= i_in;
      v_ff      <= v_in;
      k_ff      <= k_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_first_prime  = first_ff;
   assign rsp_second_prime = second_ff;

endmodule

>>> src/gpf_ctrl.sv
// Controller of the Goldbach split finder: sequences the pair search and
// trial divisions, owns the handshakes. Uses gpf_pkg.
module gpf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  gpf_pkg::sts_type sts,
   output gpf_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASS,
      S_PAIR,
      S_KCHK,
      S_DIV,
      S_REM,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic                   second_ff, second_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gpf_pkg::status_type    res_status_ff, res_status_in;
   gpf_pkg::out_sel_type   res_sel_ff, res_sel_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      res_status_in = res_status_ff;
      res_sel_in    = res_sel_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.out_status = res_status_ff;
      cmd.out_sel    = res_sel_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_n = 1'b1;
               state_in   = S_CLASS;
            end
         end
         S_CLASS: begin
            if (sts.n_odd) begin
               res_status_in = gpf_pkg::ST_ODD;
               res_sel_in    = gpf_pkg::OUT_ZERO;
               state_in      = S_DONE;
            end else if (sts.n_is_two) begin
               res_status_in = gpf_pkg::ST_TWO;
               res_sel_in    = gpf_pkg::OUT_ZERO;
               state_in      = S_DONE;
            end else if (sts.n_is_four) begin
               res_status_in = gpf_pkg::ST_FOUND;
               res_sel_in    = gpf_pkg::OUT_TWO;
               state_in      = S_DONE;
            end else begin
               cmd.pair_init = 1'b1;
               state_in      = S_PAIR;
            end
         end
         S_PAIR: begin
            if (sts.pair_end) begin
               res_status_in = gpf_pkg::ST_NONE;
               res_sel_in    = gpf_pkg::OUT_ZERO;
               state_in      = S_DONE;
            end else begin
               cmd.test_first = 1'b1;
               second_in      = 1'b0;
               state_in       = S_KCHK;
            end
         end
         S_KCHK: begin
            if (sts.sq_gt_v) begin
               // candidate survived every divisor
               if (!second_ff) begin
                  cmd.test_second = 1'b1;
                  second_in       = 1'b1;
               end else begin
                  res_status_in = gpf_pkg::ST_FOUND;
                  res_sel_in    = gpf_pkg::OUT_PAIR;
                  state_in      = S_DONE;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_REM;
            end
         end
         S_REM: begin
            if (sts.rem_zero) begin
               cmd.pair_next = 1'b1;
               state_in      = S_PAIR;
            end else begin
               cmd.k_next = 1'b1;
               state_in   = S_KCHK;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         second_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= gpf_pkg::ST_NONE;
         res_sel_ff    <= gpf_pkg::OUT_ZERO;
      end else begin
         state_ff      <= state_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_sel_ff    <= res_sel_in;
      end
   end

endmodule

>>> src/gpf_checker.sv
// Port-level checks for the Goldbach split finder, bound to the top level.
// Depends on gpf_pkg.
module gpf_checker #(
   parameter int NUM_WIDTH = 16
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_status,
   input logic [NUM_WIDTH-1:0] rsp_first_prime,
   input logic [NUM_WIDTH-1:0] rsp_second_prime
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_first_prime) && $stable(rsp_second_prime))
      else $error("result word changed while stalled");

   // no result without a split carries primes
   a_zero_primes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != gpf_pkg::ST_FOUND)
         |-> (rsp_first_prime == '0) && (rsp_second_prime == '0))
      else $error("primes reported without a split");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == gpf_pkg::ST_FOUND)
         |-> (rsp_first_prime <= rsp_second_prime) && (rsp_first_prime >= 2))
      else $error("split primes out of order");

   // block is busy right after taking a word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear handshakes");

endmodule

bind goldbach_partition_finder gpf_checker #(
   .NUM_WIDTH (NUM_WIDTH)
) u_gpf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_first_prime  (rsp_first_prime),
   .rsp_second_prime (rsp_second_prime)
);
